/* src/keyed_reference_count_table_top_assert.svh */
// Assertion macros for the keyed reference count table.
`ifndef KEYED_REFERENCE_COUNT_TABLE_TOP_ASSERT_SVH
`define KEYED_REFERENCE_COUNT_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define KRCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KRCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KRCT_ASSERT_IMP(lbl, ante, cons)
`define KRCT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/krct_pkg.sv */
// Package: sizes, codes and payload types of the keyed reference count table.
package krct_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCN_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 48;
  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_INC = 2'd0,
    REQ_DEC = 2'd1,
    REQ_QRY = 2'd2,
    REQ_RSV = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RDC,
    S_UPD,
    S_SEND
  } state_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] obj_key;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] ref_count;
    logic               table_full;
  } out_t;

endpackage

/* src/krct_ram.sv */
// Generic one-write, one-read synchronous RAM with registered read data.
module krct_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/krct_ctrl.sv */
// Request sequencer: key scan, count read-modify-write and valid bits.
module krct_ctrl import krct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_t                in_data,
  output logic               in_stall,
  input  logic [KEY_W-1:0]   key_rd,
  input  logic [COUNT_W-1:0] cnt_rd,
  output logic [IDX_W-1:0]   key_raddr,
  output logic [IDX_W-1:0]   cnt_raddr,
  output logic [IDX_W-1:0]   wr_idx,
  output logic               key_we,
  output logic [KEY_W-1:0]   key_wdata,
  output logic               cnt_we,
  output logic [COUNT_W-1:0] cnt_wdata,
  input  logic               out_free,
  output logic               res_valid,
  output out_t               res
);

  state_t state_r, state_nxt;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               cmp_pend_r, cmp_pend_nxt;
  logic               hit_r, hit_nxt;
  logic               free_fnd_r, free_fnd_nxt;
  logic [SCN_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [1:0]         req_r, req_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  out_t               res_r, res_nxt;

  logic               accept;
  logic               scan_issue;
  logic [IDX_W-1:0]   scan_idx;
  logic               key_nz;
  logic               upd_cnt_we;
  logic               upd_key_we;
  logic               upd_set;
  logic               upd_clr;
  logic [IDX_W-1:0]   upd_idx;
  logic [COUNT_W-1:0] upd_cnt;
  out_t               upd_res;

  assign accept     = in_valid && !in_stall;
  assign scan_idx   = idx_r[IDX_W-1:0];
  assign scan_issue = (state_r == S_SCAN) && (idx_r != SCN_W'(ENTRIES));
  assign key_nz     = (key_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_issue && !cmp_pend_r) begin
          state_nxt = S_RDC;
        end
      end
      S_RDC:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_SEND;
      S_SEND: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // update decision for the request once the count is read
  always_comb begin
    upd_cnt_we = 1'b0;
    upd_key_we = 1'b0;
    upd_set    = 1'b0;
    upd_clr    = 1'b0;
    upd_idx    = hit_idx_r;
    upd_cnt    = cnt_rd;
    upd_res    = '0;
    case (req_r)
      REQ_INC: begin
        if (hit_r) begin
          upd_cnt_we = 1'b1;
          upd_cnt    = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_W'(1);
          upd_res.ref_count = upd_cnt;
        end else if (key_nz && free_fnd_r) begin
          upd_cnt_we = 1'b1;
          upd_key_we = 1'b1;
          upd_set    = 1'b1;
          upd_idx    = free_idx_r;
          upd_cnt    = COUNT_W'(1);
          upd_res.ref_count = COUNT_W'(1);
        end else if (key_nz) begin
          upd_res.table_full = 1'b1;
        end
      end
      REQ_DEC: begin
        if (hit_r) begin
          upd_cnt_we = 1'b1;
          upd_cnt    = (cnt_rd != '0) ? cnt_rd - COUNT_W'(1) : '0;
          upd_clr    = (upd_cnt == '0);
          upd_res.ref_count = upd_cnt;
        end
      end
      REQ_QRY: begin
        if (hit_r) begin
          upd_res.ref_count = cnt_rd;
        end
      end
      default: upd_res = '0;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    key_raddr = scan_idx;
    cnt_raddr = hit_idx_r;
    wr_idx    = upd_idx;
    key_we    = (state_r == S_UPD) && upd_key_we;
    key_wdata = key_r;
    cnt_we    = (state_r == S_UPD) && upd_cnt_we;
    cnt_wdata = upd_cnt;
    res_valid = (state_r == S_SEND);
    res       = res_r;
  end

  // datapath next values
  always_comb begin
    valid_nxt    = valid_r;
    cmp_pend_nxt = scan_issue;
    hit_nxt      = hit_r;
    free_fnd_nxt = free_fnd_r;
    idx_nxt      = idx_r;
    cmp_idx_nxt  = scan_idx;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    req_nxt      = req_r;
    key_nxt      = key_r;
    res_nxt      = res_r;
    if (accept) begin
      idx_nxt      = '0;
      hit_nxt      = 1'b0;
      free_fnd_nxt = 1'b0;
      req_nxt      = in_data.req_type;
      key_nxt      = in_data.obj_key;
    end
    if (scan_issue) begin
      idx_nxt = idx_r + SCN_W'(1);
      if (!valid_r[scan_idx] && !free_fnd_r) begin
        free_fnd_nxt = 1'b1;
        free_idx_nxt = scan_idx;
      end
    end
    if (cmp_pend_r && !hit_r && valid_r[cmp_idx_r] && key_nz && (key_rd == key_r)) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = cmp_idx_r;
    end
    if (state_r == S_UPD) begin
      res_nxt = upd_res;
      if (upd_set) begin
        valid_nxt[upd_idx] = 1'b1;
      end
      if (upd_clr) begin
        valid_nxt[upd_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      cmp_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      cmp_pend_r <= cmp_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r      <= hit_nxt;
    free_fnd_r <= free_fnd_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
  end

endmodule

/* src/keyed_reference_count_table_top.sv */
// Top level of the keyed reference count table: key and count RAMs, sequencer, output register.
// An input transfer starts a key RAM scan at one entry per cycle, then a compare drain, the
// count read, the count and key update, and the result send into the output register.
// One request is in flight at a time; the result register lets the next request
// start while a result waits on out_stall.
// Synchronous active-low reset clears the valid bits, sequencer and output valid.
`include "keyed_reference_count_table_top_assert.svh"
module keyed_reference_count_table_top import krct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  in_t  in_data,
  output logic in_stall,
  output logic out_valid,
  output out_t out_data,
  input  logic out_stall
);

  logic [KEY_W-1:0]   key_rd;
  logic [COUNT_W-1:0] cnt_rd;
  logic [IDX_W-1:0]   key_raddr;
  logic [IDX_W-1:0]   cnt_raddr;
  logic [IDX_W-1:0]   wr_idx;
  logic               key_we;
  logic [KEY_W-1:0]   key_wdata;
  logic               cnt_we;
  logic [COUNT_W-1:0] cnt_wdata;
  logic               out_free;
  logic               res_valid;
  out_t               res;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  krct_ram #(.W(KEY_W), .D(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_idx),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  krct_ram #(.W(COUNT_W), .D(ENTRIES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (wr_idx),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  krct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .key_rd    (key_rd),
    .cnt_rd    (cnt_rd),
    .key_raddr (key_raddr),
    .cnt_raddr (cnt_raddr),
    .wr_idx    (wr_idx),
    .key_we    (key_we),
    .key_wdata (key_wdata),
    .cnt_we    (cnt_we),
    .cnt_wdata (cnt_wdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_free) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KRCT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `KRCT_ASSERT_NXT(a_result_held, res_valid && !out_free, res_valid)
  `KRCT_ASSERT_IMP(a_full_zero_count, out_valid && out_data.table_full, out_data.ref_count == '0)
  `KRCT_ASSERT_IMP(a_no_result_while_idle, res_valid, in_stall)

endmodule

/* tb/tb.sv */
// Self-checking testbench for the keyed reference count table: directed and random requests.
module tb;
  import krct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM       = 880;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 1000;

  class refcount_scoreboard;
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [COUNT_W-1:0] slot_count [ENTRIES];
    bit                 slot_used  [ENTRIES];
    out_t               expected_q [$];
    int                 errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Updates the table copy and queues the result the request should produce.
    function void note_request(in_t req);
      out_t res;
      int   hit;
      int   vacant;
      res = '0;
      hit = -1;
      vacant = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] && slot_key[i] == req.obj_key && hit < 0) hit = i;
        if (!slot_used[i] && vacant < 0) vacant = i;
      end
      if (req.obj_key != '0) begin
        case (req_t'(req.req_type))
          REQ_INC: begin
            if (hit >= 0) begin
              if (slot_count[hit] != COUNT_MAX) slot_count[hit] = slot_count[hit] + 1'b1;
              res.ref_count = slot_count[hit];
            end else if (vacant >= 0) begin
              slot_key[vacant]   = req.obj_key;
              slot_count[vacant] = COUNT_W'(1);
              slot_used[vacant]  = 1'b1;
              res.ref_count      = COUNT_W'(1);
            end else begin
              res.table_full = 1'b1;
            end
          end
          REQ_DEC: begin
            if (hit >= 0) begin
              if (slot_count[hit] != '0) slot_count[hit] = slot_count[hit] - 1'b1;
              res.ref_count = slot_count[hit];
              if (slot_count[hit] == '0) slot_used[hit] = 1'b0;
            end
          end
          REQ_QRY: begin
            if (hit >= 0) res.ref_count = slot_count[hit];
          end
          default: ;
        endcase
      end
      expected_q.push_back(res);
    endfunction

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result count=%0d full=%0b", got.ref_count,
                         got.table_full));
        return;
      end
      want = expected_q.pop_front();
      if (got.ref_count !== want.ref_count)
        report($sformatf("ref_count got %0d want %0d", got.ref_count, want.ref_count));
      if (got.table_full !== want.table_full)
        report($sformatf("table_full got %0b want %0b", got.table_full, want.table_full));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  in_t  in_data;
  logic in_stall;
  logic out_valid;
  out_t out_data;
  logic out_stall;

  refcount_scoreboard sb = new();
  logic [KEY_W-1:0]   key_pool [POOL_SIZE];
  bit                 tx_no_gaps;
  bit                 rx_no_gaps;
  int                 idle_cycles;

  keyed_reference_count_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Returns at the edge where the request transfers; valid stays high unless a gap follows.
  task automatic send_request(input req_t kind, input logic [KEY_W-1:0] key);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: kind, obj_key: key};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("FAIL keyed_reference_count_table_top");
        $finish;
      end
    end
  end

  initial begin
    int hold;
    int n_results;
    n_results = 0;
    rx_no_gaps = 1'b0;
    forever begin
      hold = rx_no_gaps ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
      n_results++;
      if (n_results % 100 == 0) rx_no_gaps = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    req_t             kind;
    logic [KEY_W-1:0] key;
    int               roll;
    bit               grow_phase;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    tx_no_gaps = 1'b0;
    grow_phase = 1'b1;
    foreach (key_pool[i]) begin
      key_pool[i] = KEY_W'({$urandom, $urandom});
      if (key_pool[i] == '0) key_pool[i] = KEY_W'(1);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // null key, reserved type, absent key, count up and down to release
    send_request(REQ_INC, '0);
    send_request(REQ_QRY, '0);
    send_request(REQ_RSV, '1);
    send_request(REQ_DEC, '1);
    send_request(REQ_INC, '1);
    send_request(REQ_INC, '1);
    send_request(REQ_DEC, '1);
    send_request(REQ_DEC, '1);
    send_request(REQ_QRY, '1);
    // fill every slot, then one insert too many
    for (int i = 0; i < ENTRIES; i++) send_request(REQ_INC, key_pool[i]);
    send_request(REQ_INC, key_pool[ENTRIES]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) tx_no_gaps = ($urandom_range(0, 2) == 0);
      if (n % 150 == 0) grow_phase = ~grow_phase;
      roll = $urandom_range(0, 99);
      if (roll < 3)               kind = REQ_RSV;
      else if (roll < 15)         kind = REQ_QRY;
      else if (roll < (grow_phase ? 70 : 40)) kind = REQ_INC;
      else                        kind = REQ_DEC;
      roll = $urandom_range(0, 99);
      if (roll < 4)       key = '0;
      else if (roll < 12) key = KEY_W'({$urandom, $urandom});
      else                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_request(kind, key);
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS keyed_reference_count_table_top");
    end else begin
      $display("FAIL keyed_reference_count_table_top");
    end
    $finish;
  end

endmodule
